// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FPE_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define FPE_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/fpe_pkg.sv
// ----------------------------------------------------------------------------
// fpe_pkg
// Types, constants, fragment table and microprogram of the enumerator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpe_pkg;

    localparam int MAX_PARTS  = 16;
    localparam int TABLE_SIZE = 100;
    localparam int ROM_DEPTH  = 100;
    localparam int IDX_W      = $clog2(MAX_PARTS);

    typedef struct packed {
        logic       func;
        logic [4:0] part_count;
        logic [4:0] target_mass;
        logic [4:0] target_charge;
    } t_req;

    typedef struct packed {
        logic       found;
        logic [6:0] fragment_number;
        logic [3:0] position;
        logic       last;
    } t_res;

    localparam logic FUNC_INIT   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // A in [8:4], Z in [3:0]
    localparam logic [8:0] FRAG_ROM [ROM_DEPTH] = '{
        9'h010, 9'h011, 9'h021, 9'h031, 9'h032,
        9'h042, 9'h052, 9'h053, 9'h062, 9'h063,
        9'h063, 9'h073, 9'h073, 9'h074, 9'h074,
        9'h083, 9'h083, 9'h084, 9'h094, 9'h095,
        9'h0A4, 9'h0A4, 9'h0A4, 9'h0A4, 9'h0A4,
        9'h0A5, 9'h0A5, 9'h0A5, 9'h0A5, 9'h0A5,
        9'h0A6, 9'h0A6, 9'h0B5, 9'h0B5, 9'h0B5,
        9'h0B5, 9'h0B5, 9'h0B5, 9'h0B5, 9'h0B5,
        9'h0B6, 9'h0B6, 9'h0B6, 9'h0B6, 9'h0B6,
        9'h0B6, 9'h0B6, 9'h0B6, 9'h0B6, 9'h0B6,
        9'h0B6, 9'h0C5, 9'h0C5, 9'h0C5, 9'h0C5,
        9'h0C6, 9'h0C6, 9'h0D6, 9'h0D6, 9'h0D6,
        9'h0D6, 9'h0D7, 9'h0E6, 9'h0E6, 9'h0E6,
        9'h0E6, 9'h0E6, 9'h0E7, 9'h0E7, 9'h0E7,
        9'h0E7, 9'h0E7, 9'h0E7, 9'h0E7, 9'h0E7,
        9'h0E7, 9'h0E7, 9'h0F7, 9'h0F7, 9'h0F7,
        9'h0F7, 9'h0F7, 9'h0F7, 9'h0F7, 9'h0F7,
        9'h0F7, 9'h0F7, 9'h0F8, 9'h0F8, 9'h0F8,
        9'h0F8, 9'h0F8, 9'h107, 9'h107, 9'h107,
        9'h107, 9'h108, 9'h108, 9'h108, 9'h108
    };

    localparam logic [8:0] FRAG_ONE = FRAG_ROM[0];

    function automatic logic [8:0] f_frag(input logic [6:0] num);
        logic [8:0] v;
        logic [6:0] ix;
        ix = num - 7'd1;
        v  = '0;
        if (num >= 7'd1 && num <= 7'(ROM_DEPTH)) begin
            v = FRAG_ROM[ix];
        end
        return v;
    endfunction

    function automatic logic [4:0] f_sat_count(input logic [4:0] cnt);
        logic [4:0] v;
        v = cnt;
        if (cnt == 5'd0) begin
            v = 5'd1;
        end else if (cnt > 5'(MAX_PARTS)) begin
            v = 5'(MAX_PARTS);
        end
        return v;
    endfunction

    // ---- microcode ----
    typedef enum logic [1:0] {
        A_IDX,
        A_NB,
        A_TOP
    } t_asel;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_START,
        C_CUR_GT_MAX,
        C_CUR_GT_NB,
        C_IDX_TOP,
        C_SA_GT,
        C_MISMATCH
    } t_cond;

    typedef logic [4:0] t_step;

    localparam t_step S_IDLE = 5'd0;
    localparam t_step S_INIT = 5'd1;
    localparam t_step S_CHK  = 5'd2;
    localparam t_step S_CHK2 = 5'd3;
    localparam t_step S_LD   = 5'd4;
    localparam t_step S_NB   = 5'd5;
    localparam t_step S_LCMP = 5'd6;
    localparam t_step S_LADD = 5'd7;
    localparam t_step S_LCHK = 5'd8;
    localparam t_step S_LMAT = 5'd9;
    localparam t_step S_LOVR = 5'd10;
    localparam t_step S_RST  = 5'd11;
    localparam t_step S_RST2 = 5'd12;
    localparam t_step S_TCHK = 5'd13;
    localparam t_step S_TADD = 5'd14;
    localparam t_step S_TSA  = 5'd15;
    localparam t_step S_TMAT = 5'd16;
    localparam t_step S_TEXH = 5'd17;
    localparam t_step S_EMIT = 5'd18;
    localparam t_step S_NF   = 5'd19;

    typedef struct packed {
        t_asel asel;
        logic  ld_cur;
        logic  ld_nb;
        logic  cur_inc;
        logic  cur_one;
        logic  sum_sub;
        logic  sum_add;
        logic  wr;
        logic  idx_clr;
        logic  idx_inc;
        logic  do_init;
        logic  emit_hit;
        logic  emit_miss;
        t_cond cond;
        t_step t_true;
        t_step t_false;
    } t_uop;

    typedef struct packed {
        logic cur_gt_max;
        logic cur_gt_nb;
        logic idx_top;
        logic sa_gt;
        logic mismatch;
    } t_flags;

    function automatic t_uop f_ucode(input t_step pc);
        t_uop u;
        u         = '0;
        u.asel    = A_IDX;
        u.cond    = C_ALWAYS;
        u.t_true  = S_IDLE;
        u.t_false = S_IDLE;
        case (pc)
            S_IDLE: begin
                u.cond = C_START; u.t_true = S_CHK; u.t_false = S_INIT;
            end
            S_INIT: begin
                u.do_init = 1'b1;
            end
            S_CHK: begin
                u.asel = A_TOP; u.ld_cur = 1'b1; u.idx_clr = 1'b1; u.t_true = S_CHK2;
            end
            S_CHK2: begin
                u.cond = C_CUR_GT_MAX; u.t_true = S_NF; u.t_false = S_LD;
            end
            S_LD: begin
                u.asel = A_IDX; u.ld_cur = 1'b1; u.t_true = S_NB;
            end
            S_NB: begin
                u.asel = A_NB; u.ld_nb = 1'b1; u.sum_sub = 1'b1; u.cur_inc = 1'b1;
                u.cond = C_IDX_TOP; u.t_true = S_TCHK; u.t_false = S_LCMP;
            end
            S_LCMP: begin
                u.cond = C_CUR_GT_NB; u.t_true = S_RST; u.t_false = S_LADD;
            end
            S_LADD: begin
                u.sum_add = 1'b1; u.wr = 1'b1; u.t_true = S_LCHK;
            end
            S_LCHK: begin
                u.cond = C_SA_GT; u.t_true = S_LOVR; u.t_false = S_LMAT;
            end
            S_LMAT: begin
                u.idx_clr = 1'b1;
                u.cond = C_MISMATCH; u.t_true = S_LD; u.t_false = S_EMIT;
            end
            S_LOVR: begin
                u.sum_sub = 1'b1; u.cur_one = 1'b1; u.t_true = S_RST2;
            end
            S_RST: begin
                u.cur_one = 1'b1; u.t_true = S_RST2;
            end
            S_RST2: begin
                u.sum_add = 1'b1; u.wr = 1'b1; u.idx_inc = 1'b1; u.t_true = S_LD;
            end
            S_TCHK: begin
                u.cond = C_CUR_GT_MAX; u.t_true = S_TEXH; u.t_false = S_TADD;
            end
            S_TADD: begin
                u.sum_add = 1'b1; u.wr = 1'b1; u.t_true = S_TSA;
            end
            S_TSA: begin
                u.cond = C_SA_GT; u.t_true = S_NF; u.t_false = S_TMAT;
            end
            S_TMAT: begin
                u.idx_clr = 1'b1;
                u.cond = C_MISMATCH; u.t_true = S_LD; u.t_false = S_EMIT;
            end
            S_TEXH: begin
                u.wr = 1'b1; u.t_true = S_NF;
            end
            S_EMIT: begin
                u.asel = A_IDX; u.emit_hit = 1'b1; u.idx_inc = 1'b1;
                u.cond = C_IDX_TOP; u.t_true = S_IDLE; u.t_false = S_EMIT;
            end
            S_NF: begin
                u.emit_miss = 1'b1;
            end
            default: begin
                u.t_true = S_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fpe_seq.sv
// ----------------------------------------------------------------------------
// fpe_seq
// Step counter and microprogram lookup with two-way conditional jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpe_seq
    import fpe_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_accept,
    input  wire logic   i_func,
    input  wire t_flags i_flags,
    output t_uop        o_uop,
    output logic        o_busy
);

    t_step r_pc;
    t_step n_pc;
    t_uop  uop;
    logic  take;

    always_comb begin
        uop  = f_ucode(r_pc);
        take = 1'b0;
        case (uop.cond)
            C_ALWAYS:     take = 1'b1;
            C_START:      take = i_func;
            C_CUR_GT_MAX: take = i_flags.cur_gt_max;
            C_CUR_GT_NB:  take = i_flags.cur_gt_nb;
            C_IDX_TOP:    take = i_flags.idx_top;
            C_SA_GT:      take = i_flags.sa_gt;
            C_MISMATCH:   take = i_flags.mismatch;
            default:      take = 1'b1;
        endcase
        n_pc = take ? uop.t_true : uop.t_false;
        if (uop.cond == C_START && !i_accept) begin
            n_pc = r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uop  = uop;
    assign o_busy = (r_pc != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/fragment_partition_enumerator_core.sv
// ----------------------------------------------------------------------------
// fragment_partition_enumerator_core
// Odometer search for K-fragment splits matching a target mass and charge.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Beat
// request   in         start & !busy            i_in  (t_req)
// result    out        o_res_stb, one cycle     o_res (t_res)
//
// Init beat: busy for the S_INIT step after the accept edge, no result.
// Search beat: data dependent; setup steps S_CHK and S_CHK2, then one pass of the
// microprogram loop per odometer step, reading through the single read port
// of the position registers, then K beats to stream the split (or one for not
// found); each result shows in the cycle after its emit step.
// Reset: synchronous; K = 1, all positions 1.
// Results cannot be stalled; a run of K beats goes out on consecutive cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fragment_partition_enumerator_core
    import fpe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_in,
    output logic      busy,
    output logic      o_res_stb,
    output t_res      o_res
);

    t_uop   uop;
    t_flags flags;
    logic   accept;

    logic [6:0]       r_parts [MAX_PARTS];
    logic [6:0]       n_parts [MAX_PARTS];
    logic [4:0]       r_k,   n_k;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [6:0]       r_cur, n_cur;
    logic [6:0]       r_nb,  n_nb;
    logic [8:0]       r_sa,  n_sa;
    logic [7:0]       r_sz,  n_sz;
    logic [4:0]       r_cnt, r_ta, r_tz;
    logic             r_stb, n_stb;
    t_res             r_res, n_res;

    logic [4:0]       k_m1;
    logic [IDX_W-1:0] rd_addr;
    logic [6:0]       rd_data;
    logic [8:0]       cur_frag;
    logic [4:0]       k_new;
    logic [9:0]       prod_a, prod_z;

    assign accept = start && !busy;

    fpe_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_func  (i_in.func),
        .i_flags (flags),
        .o_uop   (uop),
        .o_busy  (busy)
    );

    always_comb begin
        k_m1 = r_k - 5'd1;
        case (uop.asel)
            A_IDX:   rd_addr = r_idx;
            A_NB:    rd_addr = r_idx + 1'b1;
            A_TOP:   rd_addr = k_m1[IDX_W-1:0];
            default: rd_addr = r_idx;
        endcase
        rd_data  = r_parts[rd_addr];
        cur_frag = f_frag(r_cur);

        flags.cur_gt_max = (r_cur > 7'(TABLE_SIZE));
        flags.cur_gt_nb  = (r_cur > r_nb);
        flags.idx_top    = ({1'b0, r_idx} == k_m1);
        flags.sa_gt      = (r_sa > {4'd0, r_ta});
        flags.mismatch   = (r_sa != {4'd0, r_ta}) || (r_sz != {3'd0, r_tz});

        k_new  = f_sat_count(r_cnt);
        prod_a = {5'd0, k_new} * {5'd0, FRAG_ONE[8:4]};
        prod_z = {5'd0, k_new} * {6'd0, FRAG_ONE[3:0]};
    end

    always_comb begin
        n_parts = r_parts;
        n_k     = r_k;
        n_idx   = r_idx;
        n_cur   = r_cur;
        n_nb    = r_nb;
        n_sa    = r_sa;
        n_sz    = r_sz;
        n_stb   = 1'b0;
        n_res   = r_res;

        if (uop.ld_cur) begin
            n_cur = rd_data;
        end else if (uop.cur_inc) begin
            n_cur = r_cur + 7'd1;
        end else if (uop.cur_one) begin
            n_cur = 7'd1;
        end
        if (uop.ld_nb) begin
            n_nb = rd_data;
        end
        if (uop.sum_sub) begin
            n_sa = r_sa - {4'd0, cur_frag[8:4]};
            n_sz = r_sz - {4'd0, cur_frag[3:0]};
        end else if (uop.sum_add) begin
            n_sa = r_sa + {4'd0, cur_frag[8:4]};
            n_sz = r_sz + {4'd0, cur_frag[3:0]};
        end
        if (uop.wr) begin
            n_parts[r_idx] = r_cur;
        end
        if (uop.idx_clr) begin
            n_idx = '0;
        end else if (uop.idx_inc) begin
            n_idx = r_idx + 1'b1;
        end
        if (uop.do_init) begin
            for (int i = 0; i < MAX_PARTS; i++) begin
                n_parts[i] = 7'd1;
            end
            n_k  = k_new;
            n_sa = prod_a[8:0];
            n_sz = prod_z[7:0];
        end
        if (uop.emit_hit) begin
            n_stb                 = 1'b1;
            n_res.found           = 1'b1;
            n_res.fragment_number = rd_data;
            n_res.position        = 4'(r_idx);
            n_res.last            = flags.idx_top;
        end else if (uop.emit_miss) begin
            n_stb                 = 1'b1;
            n_res.found           = 1'b0;
            n_res.fragment_number = 7'd0;
            n_res.position        = 4'd0;
            n_res.last            = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PARTS; i++) begin
                r_parts[i] <= 7'd1;
            end
            r_k   <= 5'd1;
            r_sa  <= {4'd0, FRAG_ONE[8:4]};
            r_sz  <= {4'd0, FRAG_ONE[3:0]};
            r_idx <= '0;
            r_stb <= 1'b0;
        end else begin
            r_parts <= n_parts;
            r_k     <= n_k;
            r_sa    <= n_sa;
            r_sz    <= n_sz;
            r_idx   <= n_idx;
            r_stb   <= n_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_nb  <= n_nb;
        r_res <= n_res;
        if (accept) begin
            r_cnt <= i_in.part_count;
            r_ta  <= i_in.target_mass;
            r_tz  <= i_in.target_charge;
        end
    end

    assign o_res_stb = r_stb;
    assign o_res     = r_res;

endmodule

`default_nettype wire

// File: rtl/core/fpe_chk.sv
// ----------------------------------------------------------------------------
// fpe_chk
// Port-level checks on request acceptance and result runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fpe_chk
    import fpe_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_res_stb,
    input wire t_res o_res
);

    `FPE_ASSERT_IMP(a_miss_beat, i_clk, i_rst_n, o_res_stb && !o_res.found, o_res.last && o_res.fragment_number == 7'd0 && o_res.position == 4'd0)
    `FPE_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `FPE_ASSERT_NXT(a_run_next, i_clk, i_rst_n, o_res_stb && o_res.found && !o_res.last, o_res_stb && o_res.found && o_res.position == $past(o_res.position) + 4'd1)
    `FPE_ASSERT_IMP(a_hit_range, i_clk, i_rst_n, o_res_stb && o_res.found, o_res.fragment_number >= 7'd1 && o_res.fragment_number <= 7'(TABLE_SIZE))
    `FPE_ASSERT_IMP(a_run_busy, i_clk, i_rst_n, o_res_stb && !o_res.last, busy)

endmodule

bind fragment_partition_enumerator_core fpe_chk u_fpe_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_res_stb(o_res_stb),
    .o_res    (o_res)
);

`default_nettype wire
